FILE: rtl/core/shape_pose_transform_core_assert.svh
// Assertion macros for the shape pose transform core.
// Included by the top level; needs clock and reset in scope.
`ifndef SHAPE_POSE_TRANSFORM_CORE_ASSERT_SVH
`define SHAPE_POSE_TRANSFORM_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define SPT_ASSERT_IMPLY(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SPT_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/spt_pkg.sv
// Package for the shape pose transform core: widths, payload types, tables.
// No dependencies.
`default_nettype none
package spt_pkg;
   localparam int MaxTriangles = 32;
   localparam int TriIdxW      = 5;
   localparam int CountW       = 6;
   localparam int CoordW       = 20;
   localparam int AngleW       = 16;
   localparam int TrigW        = 17;
   localparam int CordW        = 24;
   localparam int CordSteps    = 16;
   localparam int StepW        = 4;
   localparam int QueueDepth   = 2;

   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   typedef struct packed {
      logic                     command;
      logic [TriIdxW-1:0]       tri_index;
      logic signed [CoordW-1:0] vert_ax;
      logic signed [CoordW-1:0] vert_ay;
      logic signed [CoordW-1:0] vert_bx;
      logic signed [CoordW-1:0] vert_by;
      logic signed [CoordW-1:0] vert_cx;
      logic signed [CoordW-1:0] vert_cy;
      logic signed [CoordW-1:0] pose_x;
      logic signed [CoordW-1:0] pose_y;
      logic signed [AngleW-1:0] pose_angle;
   } req_type;

   typedef struct packed {
      logic [TriIdxW-1:0]       out_index;
      logic signed [CoordW-1:0] out_ax;
      logic signed [CoordW-1:0] out_ay;
      logic signed [CoordW-1:0] out_bx;
      logic signed [CoordW-1:0] out_by;
      logic signed [CoordW-1:0] out_cx;
      logic signed [CoordW-1:0] out_cy;
      logic                     last_of_run;
   } rsp_type;

   // Job handed from front to back: a transform with its trig values.
   typedef struct packed {
      logic signed [CoordW-1:0] pose_x;
      logic signed [CoordW-1:0] pose_y;
      logic signed [TrigW-1:0]  sine;
      logic signed [TrigW-1:0]  cosine;
   } job_type;

   function automatic logic [AngleW-1:0] atan_lookup(input logic [StepW-1:0] i);
      logic [AngleW-1:0] r;
      case (i)
         4'd0:  r = 16'd8192;
         4'd1:  r = 16'd4836;
         4'd2:  r = 16'd2555;
         4'd3:  r = 16'd1297;
         4'd4:  r = 16'd651;
         4'd5:  r = 16'd326;
         4'd6:  r = 16'd163;
         4'd7:  r = 16'd81;
         4'd8:  r = 16'd41;
         4'd9:  r = 16'd20;
         4'd10: r = 16'd10;
         4'd11: r = 16'd5;
         4'd12: r = 16'd3;
         4'd13: r = 16'd1;
         4'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/spt_stream_if.sv
// Valid/ready channel carrying one payload type.
// Depends on nothing; payload type given by the instantiating scope.
`default_nettype none
interface spt_stream_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spt_front.sv
// Front part: accepts requests, writes loads into the vertex store,
// runs the CORDIC for transforms and pushes jobs. Depends on spt_pkg.
`default_nettype none
module spt_front import spt_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_data,
   output logic                job_valid,
   output job_type             job_data,
   input  wire logic           job_ready,
   input  wire logic           store_busy,
   output logic                st_we,
   output logic [TriIdxW-1:0]  st_addr,
   output logic [6*CoordW-1:0] st_wdata
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CORD = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type               state_ff, state_in;
   logic signed [CordW-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AngleW:0]   z_ff, z_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic                     flip_ff, flip_in;
   logic signed [CoordW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [TrigW-1:0]  sin_ff, sin_in, cos_ff, cos_in;

   logic signed [AngleW:0]   ang;
   logic signed [CordW-1:0]  dx, dy;
   logic signed [AngleW:0]   at;
   logic signed [CordW-1:0]  rx, ry;
   logic signed [TrigW-1:0]  qx, qy;

   function automatic logic signed [TrigW-1:0] q15(input logic signed [CordW-1:0] v,
                                                     input logic neg);
      logic signed [CordW-1:0] r;
      logic signed [TrigW-1:0] c;
      r = (v + CordW'(16)) >>> 5;
      if (r > CordW'(32768))        c = 17'sd32768;
      else if (r < -CordW'(32768))  c = -17'sd32768;
      else                          c = r[TrigW-1:0];
      return neg ? -c : c;
   endfunction

   // hold loads while a queued or running transform still reads the store
   assign req_ready = (state_ff == F_IDLE) &&
                      !(req_data.command == CMD_LOAD && store_busy);
   assign st_we     = req_valid && req_ready && (req_data.command == CMD_LOAD);
   assign st_addr   = req_data.tri_index;
   assign st_wdata  = {req_data.vert_ax, req_data.vert_ay, req_data.vert_bx,
                       req_data.vert_by, req_data.vert_cx, req_data.vert_cy};

   assign job_valid       = (state_ff == F_PUSH);
   assign job_data.pose_x = px_ff;
   assign job_data.pose_y = py_ff;
   assign job_data.sine   = sin_ff;
   assign job_data.cosine = cos_ff;

   assign ang = {req_data.pose_angle[AngleW-1], req_data.pose_angle};
   assign dx  = cy_ff >>> step_ff;
   assign dy  = cx_ff >>> step_ff;
   assign at  = {1'b0, atan_lookup(step_ff)};
   assign rx  = z_ff[AngleW] ? cx_ff + dx : cx_ff - dx;
   assign ry  = z_ff[AngleW] ? cy_ff - dy : cy_ff + dy;
   assign qx  = q15(rx, flip_ff);
   assign qy  = q15(ry, flip_ff);

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff; step_in = step_ff;
      flip_in = flip_ff; px_in = px_ff; py_in = py_ff;
      sin_in = sin_ff; cos_in = cos_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_data.command == CMD_TRANSFORM) begin
               state_in = F_CORD;
               px_in = req_data.pose_x;
               py_in = req_data.pose_y;
               cx_in = CordW'(636750);
               cy_in = '0;
               step_in = '0;
               if (ang > 17'sd16384) begin
                  z_in = ang - 17'sd32768; flip_in = 1'b1;
               end else if (ang < -17'sd16384) begin
                  z_in = ang + 17'sd32768; flip_in = 1'b1;
               end else begin
                  z_in = ang; flip_in = 1'b0;
               end
            end
         end
         F_CORD: begin
            cx_in = rx;
            cy_in = ry;
            z_in  = z_ff[AngleW] ? z_ff + at : z_ff - at;
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(CordSteps-1)) begin
               cos_in = qx;
               sin_in = qy;
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         sin_ff   <= '0;
         cos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sin_ff   <= sin_in;
         cos_ff   <= cos_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in; step_ff <= step_in;
      flip_ff <= flip_in; px_ff <= px_in; py_ff <= py_in;
   end
endmodule
`default_nettype wire

FILE: rtl/core/spt_queue.sv
// Short job queue between front and back parts.
// Depends on spt_pkg.
`default_nettype none
module spt_queue import spt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_data
);
   job_type    slot_ff [QueueDepth];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'(QueueDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wp_ff] <= in_data;
   end
endmodule
`default_nettype wire

FILE: rtl/core/spt_back.sv
// Back part: owns the vertex store, walks triangles of a job and rotates,
// translates and saturates each vertex. Depends on spt_pkg.
`default_nettype none
module spt_back import spt_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CountW-1:0]   tri_count,
   input  wire logic                st_we,
   input  wire logic [TriIdxW-1:0]  st_addr,
   input  wire logic [6*CoordW-1:0] st_wdata,
   input  wire logic                job_valid,
   output logic                     job_ready,
   input  wire job_type             job_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data,
   output logic                     busy
);
   localparam int AccW = CoordW + TrigW + 2;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_READ = 4'b0010,
      B_MULT = 4'b0100,
      B_OUT  = 4'b1000
   } bstate_type;

   logic [6*CoordW-1:0] mem [MaxTriangles];
   logic [6*CoordW-1:0] rd_ff;

   bstate_type          state_ff, state_in;
   job_type             job_ff;
   logic [CountW-1:0]   n_ff, t_ff;
   logic [CountW-1:0]   n_lim;
   logic [1:0]          v_ff;
   logic signed [2*CoordW+1:0] p_ff [4];
   logic signed [CoordW-1:0]   res_ff [6];
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic signed [CoordW-1:0] vx, vy;
   logic signed [AccW-1:0]   acc_x, acc_y, sh_x, sh_y;

   function automatic logic signed [CoordW-1:0] sat(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] r;
      r = (a + AccW'(16384)) >>> 15;
      if (r > AccW'(524287))        return 20'sh7FFFF;
      else if (r < -AccW'(524288))  return 20'sh80000;
      else                          return r[CoordW-1:0];
   endfunction

   assign n_lim = (tri_count > CountW'(MaxTriangles)) ? CountW'(MaxTriangles) : tri_count;
   assign job_ready = (state_ff == B_IDLE);
   assign busy = (state_ff != B_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (st_we) mem[st_addr] <= st_wdata;
      rd_ff <= mem[t_ff[TriIdxW-1:0]];
   end

   // vertex select: v_ff walks a, b, c; fields packed ax,ay,bx,by,cx,cy
   always_comb begin
      case (v_ff)
         2'd0:    begin vx = rd_ff[6*CoordW-1:5*CoordW]; vy = rd_ff[5*CoordW-1:4*CoordW]; end
         2'd1:    begin vx = rd_ff[4*CoordW-1:3*CoordW]; vy = rd_ff[3*CoordW-1:2*CoordW]; end
         default: begin vx = rd_ff[2*CoordW-1:CoordW];   vy = rd_ff[CoordW-1:0]; end
      endcase
   end

   assign acc_x = AccW'(p_ff[0]) - AccW'(p_ff[1]) + (AccW'(job_ff.pose_x) <<< 15);
   assign acc_y = AccW'(p_ff[2]) + AccW'(p_ff[3]) + (AccW'(job_ff.pose_y) <<< 15);
   assign sh_x = acc_x;
   assign sh_y = acc_y;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (job_valid) state_in = (n_lim == '0) ? B_IDLE : B_READ;
         B_READ: state_in = B_MULT;
         B_MULT: if (v_ff == 2'd3) state_in = B_OUT;
         B_OUT:  if (!rsp_valid_ff || rsp_ready)
                    state_in = (t_ff + CountW'(1) == n_ff) ? B_IDLE : B_READ;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         t_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                                  rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: if (job_valid) t_ff <= '0;
            B_OUT: if (!rsp_valid_ff || rsp_ready) t_ff <= t_ff + CountW'(1);
            default: ;
         endcase
      end
      case (state_ff)
         B_IDLE: if (job_valid) begin job_ff <= job_data; n_ff <= n_lim; end
         B_READ: v_ff <= 2'd0;
         B_MULT: begin
            // one vertex of products per cycle, summed in the next cycle
            if (v_ff != 2'd3) begin
               p_ff[0] <= (2*CoordW+2)'(job_ff.cosine * vx);
               p_ff[1] <= (2*CoordW+2)'(job_ff.sine * vy);
               p_ff[2] <= (2*CoordW+2)'(job_ff.sine * vx);
               p_ff[3] <= (2*CoordW+2)'(job_ff.cosine * vy);
            end
            case (v_ff)
               2'd1: begin res_ff[0] <= sat(sh_x); res_ff[1] <= sat(sh_y); end
               2'd2: begin res_ff[2] <= sat(sh_x); res_ff[3] <= sat(sh_y); end
               2'd3: begin res_ff[4] <= sat(sh_x); res_ff[5] <= sat(sh_y); end
               default: ;
            endcase
            v_ff <= v_ff + 2'd1;
         end
         B_OUT: if (!rsp_valid_ff || rsp_ready) begin
            rsp_ff.out_index   <= t_ff[TriIdxW-1:0];
            rsp_ff.out_ax      <= res_ff[0];
            rsp_ff.out_ay      <= res_ff[1];
            rsp_ff.out_bx      <= res_ff[2];
            rsp_ff.out_by      <= res_ff[3];
            rsp_ff.out_cx      <= res_ff[4];
            rsp_ff.out_cy      <= res_ff[5];
            rsp_ff.last_of_run <= (t_ff + CountW'(1) == n_ff);
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/core/shape_pose_transform_core.sv
// Top level of the shape pose transform core: front, job queue, back.
// Depends on spt_pkg, spt_stream_if, spt_front, spt_queue, spt_back.
//
//   channel | dir | handshake         | carries
//   req     | in  | valid/ready       | load triangle or transform pose
//   rsp     | out | valid/ready       | one transformed triangle
//   csr     | in  | write enable only | triangle_count
//
// A transform request runs in the front (sixteen CORDIC steps, one shared
// shift/add unit) and then, per triangle in the back, through the store read,
// the three vertex multiply passes plus one sum pass and the output step.
// Reset is synchronous and clears all control state; the vertex store is not
// cleared. Result stalls hold the back part; the job queue lets the front take
// two more transforms, while loads wait until no transform is queued or in the
// back so that a run sees a stable shape.
`default_nettype none
`include "shape_pose_transform_core_assert.svh"
module shape_pose_transform_core import spt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   spt_stream_if.sink        req,
   spt_stream_if.source      rsp,
   input  wire logic         csr_we,
   input  wire logic [CountW-1:0] csr_wdata
);
   logic [CountW-1:0] count_ff;
   logic              job_valid, job_ready, qjob_valid, qjob_ready;
   job_type           job_data, qjob_data;
   logic              st_we;
   logic [TriIdxW-1:0] st_addr;
   logic [6*CoordW-1:0] st_wdata;
   logic              busy;
   logic              store_busy;
   req_type           req_payload;
   rsp_type           rsp_payload;

   // Hold the triangle count; it must be written only while idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset)       count_ff <= '0;
      else if (csr_we) count_ff <= csr_wdata;
   end

   assign req_payload = req.data;
   assign rsp.data    = rsp_payload;

   // A transform waiting in the queue or running in the back still reads the store.
   assign store_busy = qjob_valid || busy;

   spt_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req_payload),
      .job_valid, .job_data, .job_ready, .store_busy,
      .st_we, .st_addr, .st_wdata
   );

   spt_queue u_queue (
      .clock, .reset,
      .in_valid(job_valid), .in_ready(job_ready), .in_data(job_data),
      .out_valid(qjob_valid), .out_ready(qjob_ready), .out_data(qjob_data)
   );

   spt_back u_back (
      .clock, .reset, .tri_count(count_ff),
      .st_we, .st_addr, .st_wdata,
      .job_valid(qjob_valid), .job_ready(qjob_ready), .job_data(qjob_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp_payload),
      .busy
   );

   `SPT_ASSERT_IMPLY(a_store_write_accepted, st_we, req.valid && req.ready,
      "store written without an accepted load")
   `SPT_ASSERT_NEXT(a_rsp_held, rsp.valid && !rsp.ready, rsp.valid,
      "result dropped while stalled")
   `SPT_ASSERT_IMPLY(a_rsp_means_busy, rsp.valid, busy,
      "result shown while back part idle")
endmodule
`default_nettype wire

FILE: bench/shape_pose_transform_core_tb.sv
// Testbench for shape_pose_transform_core: loads triangles, transforms them by directed
// and random poses and checks every result against an in-bench predictor or typed row.
// Depends on spt_pkg, spt_stream_if and the core RTL.
`default_nettype none
module shape_pose_transform_core_tb;
   import spt_pkg::*;

   localparam int GapMax      = 18;
   localparam int HoldCycles  = 600;   // receiver hold-off, long enough to fill the queue
   localparam int DrainCycles = 250;   // covers a transform still in the front
   localparam int StallLimit  = 20000; // cycles without any handshake
   localparam int RandomItems = 330;
   localparam int Q15One      = 32768;
   localparam int SatMax      = 524287;
   localparam int SatMin      = -524288;
   localparam int ArcTable [CordSteps] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                           41, 20, 10, 5, 3, 1, 1, 0};

   typedef struct {
      req_type cmd;
      bit      typed;   // expected result written out by hand
      rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CountW-1:0] csr_wdata = '0;

   spt_stream_if #(.payload_type(req_type)) req_ch (clock);
   spt_stream_if #(.payload_type(rsp_type)) rsp_ch (clock);

   shape_pose_transform_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   int          shape_x [3*MaxTriangles];
   int          shape_y [3*MaxTriangles];
   bit          slot_loaded [MaxTriangles];
   int          sin_q15;
   int          cos_q15;
   int          tri_count;
   rsp_type     pending_triangles [$];

   int          error_count = 0;
   int          idle_cycles = 0;
   bit          rsp_hold_req = 1'b0;
   bit          rsp_no_stall = 1'b0;
   bit          req_no_gap = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int round_trig(longint v);
      longint r;
      r = (v + 16) >>> 5;
      if (r > Q15One) r = Q15One;
      if (r < -Q15One) r = -Q15One;
      return int'(r);
   endfunction

   // Fold the heading into +-pi/2, run the CORDIC, unfold.
   function automatic void update_trig(logic signed [AngleW-1:0] heading);
      int     z;
      bit     flip;
      longint x, y, dx, dy;
      z = heading;
      flip = 1'b0;
      x = 636750;
      y = 0;
      if (z > 16384) begin
         z -= 32768;
         flip = 1'b1;
      end else if (z < -16384) begin
         z += 32768;
         flip = 1'b1;
      end
      for (int i = 0; i < CordSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTable[i];
         end else begin
            x += dx; y -= dy; z += ArcTable[i];
         end
      end
      cos_q15 = round_trig(x);
      sin_q15 = round_trig(y);
      if (flip) begin
         cos_q15 = -cos_q15;
         sin_q15 = -sin_q15;
      end
   endfunction

   function automatic logic signed [CoordW-1:0] round_coord(longint acc);
      longint r;
      r = (acc + 16384) >>> 15;
      if (r > SatMax) r = SatMax;
      if (r < SatMin) r = SatMin;
      return r[CoordW-1:0];
   endfunction

   function automatic int active_triangles();
      return (tri_count > MaxTriangles) ? MaxTriangles : tri_count;
   endfunction

   // Apply one accepted request to the predictor; queue the triangles it emits.
   function automatic void apply_request(req_type r);
      longint px, py, vx, vy;
      int     n;
      rsp_type o;
      logic signed [CoordW-1:0] res [6];
      if (r.command == CMD_LOAD) begin
         shape_x[3*r.tri_index]   = $signed(r.vert_ax);
         shape_y[3*r.tri_index]   = $signed(r.vert_ay);
         shape_x[3*r.tri_index+1] = $signed(r.vert_bx);
         shape_y[3*r.tri_index+1] = $signed(r.vert_by);
         shape_x[3*r.tri_index+2] = $signed(r.vert_cx);
         shape_y[3*r.tri_index+2] = $signed(r.vert_cy);
         slot_loaded[r.tri_index] = 1'b1;
         return;
      end
      px = longint'($signed(r.pose_x)) * Q15One;
      py = longint'($signed(r.pose_y)) * Q15One;
      update_trig(r.pose_angle);
      n = active_triangles();
      for (int t = 0; t < n; t++) begin
         for (int j = 0; j < 3; j++) begin
            vx = shape_x[3*t+j];
            vy = shape_y[3*t+j];
            res[2*j]   = round_coord(cos_q15 * vx - sin_q15 * vy + px);
            res[2*j+1] = round_coord(sin_q15 * vx + cos_q15 * vy + py);
         end
         o.out_index   = t[TriIdxW-1:0];
         o.out_ax      = res[0];
         o.out_ay      = res[1];
         o.out_bx      = res[2];
         o.out_by      = res[3];
         o.out_cx      = res[4];
         o.out_cy      = res[5];
         o.last_of_run = (t + 1 == n);
         pending_triangles.insert(pending_triangles.size(), o);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one request, hold it until accepted, then update the predictor.
   task automatic send_request(req_type r);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, GapMax);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      apply_request(r);
      @(negedge clock);
   endtask

   // Write triangle_count while the core is idle.
   task automatic write_count(int value);
      req_ch.valid <= 1'b0;
      wait (pending_triangles.size() == 0);
      repeat (DrainCycles) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[CountW-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      tri_count = value;
   endtask

   function automatic logic signed [CoordW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return SatMax;
         1: return SatMin;
         2, 3: return $urandom_range(0, 8191) - 4096;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [AngleW-1:0] rand_heading();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 16384;
         3: return -16384;
         4: return 16385;
         5: return -16385;
         default: return $urandom();
      endcase
   endfunction

   // Random request with junk in the fields the command ignores.
   function automatic req_type rand_request(logic cmd, int slot);
      req_type r;
      r.command    = cmd;
      r.tri_index  = (slot >= 0) ? slot[TriIdxW-1:0] : TriIdxW'($urandom());
      r.vert_ax    = rand_coord();
      r.vert_ay    = rand_coord();
      r.vert_bx    = rand_coord();
      r.vert_by    = rand_coord();
      r.vert_cx    = rand_coord();
      r.vert_cy    = rand_coord();
      r.pose_x     = rand_coord();
      r.pose_y     = rand_coord();
      r.pose_angle = rand_heading();
      return r;
   endfunction

   // Receiver: draw a stall per result, or hold off for a long stretch on request.
   initial begin : rsp_side
      int gap;
      @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            rsp_hold_req = 1'b0;
         end
         gap = rsp_no_stall ? 0 : $urandom_range(0, GapMax);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (pending_triangles.size() == 0) begin
            $error("unexpected triangle result, index %0d", got.out_index);
            error_count++;
         end else begin
            want = pending_triangles.pop_front();
            if (got.out_index !== want.out_index) begin
               $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
               error_count++;
            end
            if (got.out_ax !== want.out_ax) begin
               $error("out_ax: expected %0d, got %0d", want.out_ax, got.out_ax);
               error_count++;
            end
            if (got.out_ay !== want.out_ay) begin
               $error("out_ay: expected %0d, got %0d", want.out_ay, got.out_ay);
               error_count++;
            end
            if (got.out_bx !== want.out_bx) begin
               $error("out_bx: expected %0d, got %0d", want.out_bx, got.out_bx);
               error_count++;
            end
            if (got.out_by !== want.out_by) begin
               $error("out_by: expected %0d, got %0d", want.out_by, got.out_by);
               error_count++;
            end
            if (got.out_cx !== want.out_cx) begin
               $error("out_cx: expected %0d, got %0d", want.out_cx, got.out_cx);
               error_count++;
            end
            if (got.out_cy !== want.out_cy) begin
               $error("out_cy: expected %0d, got %0d", want.out_cy, got.out_cy);
               error_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                      got.last_of_run);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (idle_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : main_flow
      stim_row_type rows [$];
      stim_row_type row;
      rsp_type   edge_rsp;
      req_type   r;
      int        phase_counts [10] = '{0, 1, 3, 32, 2, 63, 7, 33, 17, 5};
      int        n;
      bit        prefix_ok;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, one triangle in the shape.
      write_count(1);

      // Zero triangle at slot 0: the result is the pose translation itself.
      row.cmd = rand_request(CMD_LOAD, 0);
      row.cmd.vert_ax = 0; row.cmd.vert_ay = 0; row.cmd.vert_bx = 0;
      row.cmd.vert_by = 0; row.cmd.vert_cx = 0; row.cmd.vert_cy = 0;
      row.typed = 1'b0;
      rows.insert(rows.size(), row);
      edge_rsp = '{out_index: 0, out_ax: SatMax, out_ay: SatMin, out_bx: SatMax,
                   out_by: SatMin, out_cx: SatMax, out_cy: SatMin, last_of_run: 1'b1};
      row.cmd = rand_request(CMD_TRANSFORM, -1);
      row.cmd.pose_x = SatMax; row.cmd.pose_y = SatMin; row.cmd.pose_angle = 0;
      row.typed = 1'b1;
      row.want = edge_rsp;
      rows.insert(rows.size(), row);
      edge_rsp = '{out_index: 0, out_ax: SatMin, out_ay: SatMax, out_bx: SatMin,
                   out_by: SatMax, out_cx: SatMin, out_cy: SatMax, last_of_run: 1'b1};
      row.cmd.pose_x = SatMin; row.cmd.pose_y = SatMax; row.cmd.pose_angle = -32768;
      row.want = edge_rsp;
      rows.insert(rows.size(), row);

      // Extreme vertices, then the folding corners of the heading, saturating poses.
      row.typed = 1'b0;
      row.cmd = rand_request(CMD_LOAD, 0);
      row.cmd.vert_ax = SatMax; row.cmd.vert_ay = SatMin; row.cmd.vert_bx = SatMin;
      row.cmd.vert_by = SatMax; row.cmd.vert_cx = SatMax; row.cmd.vert_cy = SatMax;
      rows.insert(rows.size(), row);
      foreach (ArcTable[k]) begin
         if (k < 10) begin
            row.cmd = rand_request(CMD_TRANSFORM, -1);
            case (k)
               0: row.cmd.pose_angle = 0;
               1: row.cmd.pose_angle = 16384;
               2: row.cmd.pose_angle = -16384;
               3: row.cmd.pose_angle = 16385;
               4: row.cmd.pose_angle = -16385;
               5: row.cmd.pose_angle = 32767;
               6: row.cmd.pose_angle = -32768;
               7: row.cmd.pose_angle = 8192;
               8: row.cmd.pose_angle = -8192;
               default: row.cmd.pose_angle = 1;
            endcase
            if (k % 2 == 0) begin
               row.cmd.pose_x = 0;
               row.cmd.pose_y = 0;
            end
            rows.insert(rows.size(), row);
         end
      end
      // Loads to the top slot and to slot 1 with random values, and a transform.
      row.cmd = rand_request(CMD_LOAD, MaxTriangles - 1);
      rows.insert(rows.size(), row);
      row.cmd = rand_request(CMD_LOAD, 1);
      rows.insert(rows.size(), row);
      row.cmd = rand_request(CMD_TRANSFORM, -1);
      rows.insert(rows.size(), row);

      foreach (rows[k]) begin
         send_request(rows[k].cmd);
         if (rows[k].typed) begin
            // the predictor has queued its answer; hold the hand-written one instead
            void'(pending_triangles.pop_back());
            pending_triangles.insert(pending_triangles.size(), rows[k].want);
         end
      end

      // Random part: one phase per count setting, including empty and oversized.
      for (int p = 0; p < 10; p++) begin
         write_count(phase_counts[p]);
         rsp_no_stall = (p == 4);
         req_no_gap   = (p == 6);
         if (p == 2) rsp_hold_req = 1'b1;   // long stall while requests keep coming
         n = active_triangles();
         for (int i = 0; i < RandomItems / 10; i++) begin
            prefix_ok = 1'b1;
            for (int s = 0; s < n; s++)
               if (!slot_loaded[s]) prefix_ok = 1'b0;
            if ($urandom_range(0, 99) < 55 && prefix_ok) begin
               r = rand_request(CMD_TRANSFORM, -1);
            end else if (!prefix_ok) begin
               // fill the shape in order before any transform reads it
               for (int s = n - 1; s >= 0; s--)
                  if (!slot_loaded[s]) r = rand_request(CMD_LOAD, s);
            end else begin
               r = rand_request(CMD_LOAD, -1);
            end
            send_request(r);
         end
      end

      req_ch.valid <= 1'b0;
      wait (pending_triangles.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
